/* rtl/msf_pkg.sv */
// Package: shared constants, register map and types of the sensor filter bank.
package msf_pkg;

  localparam int NUM_CHANNELS_DEF    = 5;
  localparam int SAMPLE_BITS_DEF     = 10;
  localparam int ALPHA_FRAC_BITS_DEF = 15;

  localparam int BANK_SIZE    = 5;
  localparam int CHAN_W       = 3;
  localparam int VALUE_W      = 16;
  localparam int ALPHA_W      = 16;
  localparam int RUDDER_SHIFT = 6;
  localparam int CURRENT_CHAN = 2;
  localparam int RUDDER_CHAN  = 0;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [ALPHA_W-1:0]   ALPHA_RESET  = 16'd32768;
  localparam logic [BANK_SIZE-1:0] ENABLE_RESET = '1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ALPHA_RUDDER     = 3'd0,
    REG_ALPHA_VOLTAGE    = 3'd1,
    REG_ALPHA_CURRENT    = 3'd2,
    REG_ALPHA_CTRL_TEMP  = 3'd3,
    REG_ALPHA_MOTOR_TEMP = 3'd4,
    REG_CHANNEL_ENABLE   = 3'd5,
    REG_DUAL_CURRENT     = 3'd6
  } reg_idx_e;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

/* rtl/msf_if.sv */
// Interfaces: sample word channel and filtered result word channel.
interface msf_sample_if #(
  parameter int SAMPLE_BITS = msf_pkg::SAMPLE_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [msf_pkg::CHAN_W-1:0] channel;
  logic [SAMPLE_BITS-1:0]    sample;
  logic [SAMPLE_BITS-1:0]    second_sample;

  modport source (output valid, output channel, output sample, output second_sample,
                  input ready);
  modport sink   (input valid, input channel, input sample, input second_sample,
                  output ready);
endinterface

interface msf_result_if;
  logic                      valid;
  logic                      ready;
  logic [msf_pkg::VALUE_W-1:0] filtered_value;
  logic                      channel_ok;

  modport source (output valid, output filtered_value, output channel_ok, input ready);
  modport sink   (input valid, input filtered_value, input channel_ok, output ready);
endinterface

/* rtl/multichannel_ema_sensor_filter_unit.sv */
// Top level: five-channel exponential smoothing filter bank with APB register port.
//
// Each sample word on a valid, enabled channel updates the smoothing filter of that
// channel, and every word yields one result word. A word is taken into an input
// register, passes one multiply and one add (h + a*(x-h) >> F) into the result register
// and writes the channel's history in the same cycle, so the block takes one word per
// clock while the result side does not stall it. A result word is offered from the result
// register after the input register; the combinational path through the multiplier and
// the history register read-modify-write keeps this rate. The user must write registers
// through APB only while no word is in flight; the block itself does not enforce this.
module multichannel_ema_sensor_filter_unit #(
  parameter int NUM_CHANNELS    = msf_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLE_BITS     = msf_pkg::SAMPLE_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = msf_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  msf_sample_if.sink                   in_i,
  msf_result_if.source                 out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msf_pkg::PADDR_W-1:0]  paddr,
  input  logic [msf_pkg::PDATA_W-1:0]  pwdata,
  output logic [msf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW = msf_pkg::ALPHA_W + 1;
  localparam logic [AW-1:0] AlphaOne = AW'(1) << ALPHA_FRAC_BITS;
  localparam int VW = msf_pkg::VALUE_W;
  localparam int CW = msf_pkg::CHAN_W;
  localparam int PADDR_HI = msf_pkg::REG_IDX_W + 1;

  logic [msf_pkg::ALPHA_W-1:0]   alpha_q [msf_pkg::BANK_SIZE];
  logic [msf_pkg::BANK_SIZE-1:0] enable_q;
  logic                          dual_q;
  msf_pkg::value_t               filt_q  [msf_pkg::BANK_SIZE];
  logic [msf_pkg::BANK_SIZE-1:0] seeded_q;

  logic                   s1_valid_q;
  logic [CW-1:0]          s1_chan_q;
  logic [SAMPLE_BITS-1:0] s1_samp_q;
  logic [SAMPLE_BITS-1:0] s1_samp2_q;

  logic            out_valid_q;
  msf_pkg::value_t out_value_q;
  logic            out_ok_q;

  logic            advance;
  logic            update;
  logic            wr_en;
  msf_pkg::reg_idx_e wr_idx;

  logic                   chan_ok;
  logic [CW-1:0]          idx;
  logic                   chan_en;
  logic [31:0]            rud_wide;
  logic [SAMPLE_BITS-1:0] cur_max;
  msf_pkg::value_t        x_val;
  msf_pkg::value_t        h_val;
  logic [AW-1:0]          alpha_eff;
  logic signed [VW:0]     diff;
  logic signed [AW+VW+1:0] prod;
  logic signed [AW+VW+1:0] step;
  msf_pkg::value_t        new_val;
  msf_pkg::value_t        res_value;

  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign update    = s1_valid_q && advance && chan_ok && chan_en;

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_value = out_value_q;
  assign out_o.channel_ok     = out_ok_q;

  // datapath
  assign chan_ok = ({1'b0, s1_chan_q} < (CW+1)'(msf_pkg::BANK_SIZE)) &&
                   ({1'b0, s1_chan_q} < (CW+1)'(NUM_CHANNELS));
  assign idx     = chan_ok ? s1_chan_q : '0;
  assign chan_en = enable_q[idx];
  assign h_val   = filt_q[idx];

  always_comb begin
    rud_wide = 32'(s1_samp_q) << msf_pkg::RUDDER_SHIFT;
    cur_max  = (dual_q && (s1_samp2_q > s1_samp_q)) ? s1_samp2_q : s1_samp_q;
    if (idx == CW'(msf_pkg::RUDDER_CHAN)) begin
      x_val = (rud_wide[31:VW] != '0) ? '1 : rud_wide[VW-1:0];
    end else if (idx == CW'(msf_pkg::CURRENT_CHAN)) begin
      x_val = VW'(cur_max);
    end else begin
      x_val = VW'(s1_samp_q);
    end
  end

  always_comb begin
    alpha_eff = (AW'(alpha_q[idx]) > AlphaOne) ? AlphaOne : AW'(alpha_q[idx]);
    diff      = $signed({1'b0, x_val}) - $signed({1'b0, h_val});
    prod      = $signed({1'b0, alpha_eff}) * diff;
    step      = prod >>> ALPHA_FRAC_BITS;
    new_val   = seeded_q[idx] ? (h_val + step[VW-1:0]) : x_val;
    res_value = (chan_ok && chan_en) ? new_val : '0;
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_chan_q  <= in_i.channel;
      s1_samp_q  <= in_i.sample;
      s1_samp2_q <= in_i.second_sample;
    end
    if (advance && s1_valid_q) begin
      out_value_q <= res_value;
      out_ok_q    <= chan_ok;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = msf_pkg::reg_idx_e'(paddr[PADDR_HI:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < msf_pkg::BANK_SIZE; c++) begin
        alpha_q[c] <= msf_pkg::ALPHA_RESET;
        filt_q[c]  <= '0;
      end
      enable_q <= msf_pkg::ENABLE_RESET;
      dual_q   <= 1'b0;
      seeded_q <= '0;
    end else begin
      if (update) begin
        filt_q[idx]   <= new_val;
        seeded_q[idx] <= 1'b1;
      end
      if (wr_en) begin
        unique case (wr_idx)
          msf_pkg::REG_ALPHA_RUDDER, msf_pkg::REG_ALPHA_VOLTAGE,
          msf_pkg::REG_ALPHA_CURRENT, msf_pkg::REG_ALPHA_CTRL_TEMP,
          msf_pkg::REG_ALPHA_MOTOR_TEMP: begin
            alpha_q[wr_idx] <= pwdata[msf_pkg::ALPHA_W-1:0];
          end
          msf_pkg::REG_CHANNEL_ENABLE: begin
            enable_q <= pwdata[msf_pkg::BANK_SIZE-1:0];
            for (int c = 0; c < msf_pkg::BANK_SIZE; c++) begin
              if (!pwdata[c]) begin
                filt_q[c]   <= '0;
                seeded_q[c] <= 1'b0;
              end
            end
          end
          msf_pkg::REG_DUAL_CURRENT: begin
            dual_q <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      msf_pkg::REG_ALPHA_RUDDER, msf_pkg::REG_ALPHA_VOLTAGE,
      msf_pkg::REG_ALPHA_CURRENT, msf_pkg::REG_ALPHA_CTRL_TEMP,
      msf_pkg::REG_ALPHA_MOTOR_TEMP: begin
        prdata = msf_pkg::PDATA_W'(alpha_q[wr_idx]);
      end
      msf_pkg::REG_CHANNEL_ENABLE: begin
        prdata = msf_pkg::PDATA_W'(enable_q);
      end
      msf_pkg::REG_DUAL_CURRENT: begin
        prdata = msf_pkg::PDATA_W'(dual_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

/* rtl/msf_checker.sv */
// Checker: port-level properties of the filter bank, bound to the top level.
module msf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [msf_pkg::VALUE_W-1:0]   out_value,
  input logic                          out_ok
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ok))
    else $error("result word dropped or changed while stalled");

  a_bad_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ok |-> out_value == '0)
    else $error("invalid channel gave a non-zero value");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("accepted sample word produced no result in time");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled while result side is empty");

endmodule

bind multichannel_ema_sensor_filter_unit msf_checker u_msf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.filtered_value),
  .out_ok    (out_o.channel_ok)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench: checks the sensor filter bank against a cycle-free filter predictor.

class filter_bank_tracker;
  localparam logic [16:0] UNITY = 17'd1 << msf_pkg::ALPHA_FRAC_BITS_DEF;

  logic [15:0] alpha[5];
  logic [4:0]  enable;
  logic        dual;
  logic [15:0] hist[5];
  logic [4:0]  seeded;

  logic [15:0] want_value[$];
  logic        want_ok[$];

  int errors;
  int checked;
  int invalid_seen;

  function void clear();
    for (int c = 0; c < 5; c++) begin
      alpha[c] = msf_pkg::ALPHA_RESET;
      hist[c]  = '0;
    end
    enable = msf_pkg::ENABLE_RESET;
    dual   = 1'b0;
    seeded = '0;
    want_value.delete();
    want_ok.delete();
    errors = 0;
    checked = 0;
    invalid_seen = 0;
  endfunction

  function void write_reg(msf_pkg::reg_idx_e idx, logic [31:0] data);
    case (idx)
      msf_pkg::REG_ALPHA_RUDDER:     alpha[0] = data[15:0];
      msf_pkg::REG_ALPHA_VOLTAGE:    alpha[1] = data[15:0];
      msf_pkg::REG_ALPHA_CURRENT:    alpha[2] = data[15:0];
      msf_pkg::REG_ALPHA_CTRL_TEMP:  alpha[3] = data[15:0];
      msf_pkg::REG_ALPHA_MOTOR_TEMP: alpha[4] = data[15:0];
      msf_pkg::REG_CHANNEL_ENABLE: begin
        enable = data[4:0];
        for (int c = 0; c < 5; c++) begin
          if (!enable[c]) begin
            hist[c]   = '0;
            seeded[c] = 1'b0;
          end
        end
      end
      msf_pkg::REG_DUAL_CURRENT:     dual = data[0];
      default: ;
    endcase
  endfunction

  function logic [15:0] blend(logic [15:0] a_reg, logic [15:0] x, logic [15:0] h);
    logic [16:0] a;
    logic [32:0] acc;
    a   = (17'(a_reg) > UNITY) ? UNITY : 17'(a_reg);
    acc = 33'(a) * 33'(x) + 33'(UNITY - a) * 33'(h);
    return acc[msf_pkg::ALPHA_FRAC_BITS_DEF +: 16];
  endfunction

  function void note_sample(logic [2:0] ch, logic [9:0] s, logic [9:0] s2);
    logic [15:0] x;
    int c;
    c = ch;
    if (c >= msf_pkg::BANK_SIZE) begin
      invalid_seen++;
      want_value.push_back('0);
      want_ok.push_back(1'b0);
      return;
    end
    if (!enable[c]) begin
      want_value.push_back('0);
      want_ok.push_back(1'b1);
      return;
    end
    x = 16'(s);
    if (c == msf_pkg::RUDDER_CHAN) begin
      x = 16'(s) << msf_pkg::RUDDER_SHIFT;
    end else if (c == msf_pkg::CURRENT_CHAN && dual && s2 > s) begin
      x = 16'(s2);
    end
    if (!seeded[c]) begin
      hist[c]   = x;
      seeded[c] = 1'b1;
    end else begin
      hist[c] = blend(alpha[c], x, hist[c]);
    end
    want_value.push_back(hist[c]);
    want_ok.push_back(1'b1);
  endfunction

  function void check_value(logic [15:0] value, logic ok);
    logic [15:0] v_exp;
    logic        ok_exp;
    if (want_value.size() == 0) begin
      $display("%0t: unexpected word: filtered_value %0d channel_ok %0b", $time, value, ok);
      errors++;
      return;
    end
    v_exp  = want_value.pop_front();
    ok_exp = want_ok.pop_front();
    checked++;
    if (value !== v_exp) begin
      $display("%0t: filtered_value expected %0d got %0d", $time, v_exp, value);
      errors++;
    end
    if (ok !== ok_exp) begin
      $display("%0t: channel_ok expected %0b got %0b", $time, ok_exp, ok);
      errors++;
    end
  endfunction

  function int pending();
    return want_value.size();
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [msf_pkg::PADDR_W-1:0] paddr;
  logic [msf_pkg::PDATA_W-1:0] pwdata;
  logic [msf_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  msf_sample_if #(.SAMPLE_BITS(msf_pkg::SAMPLE_BITS_DEF)) smp_if ();
  msf_result_if res_if ();

  multichannel_ema_sensor_filter_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (smp_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  filter_bank_tracker bank;
  bit quiet;
  int rx_hold;
  int rx_stall;
  int settings;
  int cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      bank.check_value(res_if.filtered_value, res_if.channel_ok);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] pick_alpha();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd32768;
    if (r == 2) return 16'd65535;
    if (r == 3) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(1, 32767));
  endfunction

  // hold ready low for a requested stretch, else stall at random
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        res_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        res_if.ready = 1'b0;
        rx_stall--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        rx_stall = pick_gap();
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  task automatic wait_drained();
    smp_if.valid = 1'b0;
    while (bank.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_write(input msf_pkg::reg_idx_e idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    bank.write_reg(idx, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input logic [15:0] a0, input logic [15:0] a1,
                           input logic [15:0] a2, input logic [15:0] a3,
                           input logic [15:0] a4, input logic [4:0] en,
                           input logic dual_on);
    wait_drained();
    reg_write(msf_pkg::REG_ALPHA_RUDDER, 32'(a0));
    reg_write(msf_pkg::REG_ALPHA_VOLTAGE, 32'(a1));
    reg_write(msf_pkg::REG_ALPHA_CURRENT, 32'(a2));
    reg_write(msf_pkg::REG_ALPHA_CTRL_TEMP, 32'(a3));
    reg_write(msf_pkg::REG_ALPHA_MOTOR_TEMP, 32'(a4));
    reg_write(msf_pkg::REG_CHANNEL_ENABLE, 32'(en));
    reg_write(msf_pkg::REG_DUAL_CURRENT, 32'(dual_on));
    settings++;
  endtask

  task automatic send_word(input logic [2:0] ch, input logic [9:0] s, input logic [9:0] s2);
    int gap;
    smp_if.valid         = 1'b1;
    smp_if.channel       = ch;
    smp_if.sample        = s;
    smp_if.second_sample = s2;
    do @(posedge clk_i); while (!smp_if.ready);
    bank.note_sample(ch, s, s2);
    @(negedge clk_i);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      smp_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    int n_items;
    logic [2:0] ch;
    bank = new();
    bank.clear();
    quiet    = 1'b1;
    rx_hold  = 0;
    rx_stall = 0;
    settings = 0;
    cycles   = 0;
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    smp_if.valid         = 1'b0;
    smp_if.channel       = '0;
    smp_if.sample        = '0;
    smp_if.second_sample = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // seed every channel, then invalid channel numbers
    send_word(3'd0, 10'd1023, 10'd0);
    send_word(3'd0, 10'd0, 10'd1023);
    send_word(3'd1, 10'd0, 10'd1023);
    send_word(3'd1, 10'd1023, 10'd0);
    send_word(3'd2, 10'd512, 10'd1023);
    send_word(3'd3, 10'd1, 10'd0);
    send_word(3'd4, 10'd1023, 10'd1023);
    send_word(3'd5, 10'd1023, 10'd1023);
    send_word(3'd6, 10'd0, 10'd0);
    send_word(3'd7, 10'd341, 10'd682);

    configure(16'd0, 16'd16384, 16'd65535, 16'd32769, 16'd1, 5'b01010, 1'b1);
    send_word(3'd0, 10'd700, 10'd0);
    send_word(3'd1, 10'd1023, 10'd0);
    send_word(3'd2, 10'd300, 10'd900);
    send_word(3'd3, 10'd1023, 10'd0);
    send_word(3'd4, 10'd500, 10'd0);

    configure(16'd0, 16'd16384, 16'd65535, 16'd32769, 16'd1, 5'b11111, 1'b1);
    send_word(3'd0, 10'd100, 10'd0);
    send_word(3'd0, 10'd1023, 10'd0);
    send_word(3'd2, 10'd100, 10'd900);
    send_word(3'd2, 10'd1023, 10'd5);
    send_word(3'd2, 10'd10, 10'd20);
    send_word(3'd3, 10'd0, 10'd0);
    send_word(3'd4, 10'd1023, 10'd0);
    send_word(3'd4, 10'd0, 10'd0);
    smp_if.valid = 1'b0;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 5'd31, 1'b0);
        1: configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 5'd31, 1'b1);
        2: configure(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 5'd31, 1'b0);
        3: configure(pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha(),
                     5'd0, 1'b1);
        default: configure(pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha(),
                           pick_alpha(), 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      endcase
      quiet   = (p == 0 || p == 6);
      n_items = (p == 3) ? 40 : 250;
      for (int i = 0; i < n_items; i++) begin
        if (p == 4 && i == 60) rx_hold = 400;
        if (p == 5 && i == 120) begin
          smp_if.valid = 1'b0;
          wait_drained();
        end
        ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_word(ch, pick_sample(), pick_sample());
      end
      smp_if.valid = 1'b0;
    end

    quiet = 1'b1;
    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Checked %0d filtered words across %0d register settings (%0d on invalid channels)",
             bank.checked, settings, bank.invalid_seen);
    $display("Covered alpha at zero, unity and above unity, all enable masks at the ends, dual sense");
    if (bank.errors == 0 && bank.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (bank.pending() != 0) begin
        $display("%0t: %0d expected words never arrived", $time, bank.pending());
      end
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/msf_pkg.sv
rtl/msf_if.sv
rtl/multichannel_ema_sensor_filter_unit.sv
rtl/msf_checker.sv
bench/tb_top.sv
